FILE: hw/rtl/priority_ready_queue_macros.svh
// assertion macros for the priority ready queue
// used by the rtl files that carry assertions; no other dependencies
`ifndef PRIORITY_READY_QUEUE_MACROS_SVH
`define PRIORITY_READY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is held
`define PRQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("priority_ready_queue check failed");
// implication check, off while reset is held
`define PRQ_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("priority_ready_queue check failed");
`else
`define PRQ_ASSERT(label, clk, rst_n, prop)
`define PRQ_ASSERT_IMP(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: hw/rtl/prq_pkg.sv
// types and constants shared by the priority ready queue
// no dependencies
package prq_pkg;

  localparam int QueueDepth = 16;
  localparam int IdW        = 16;
  localparam int PriW       = 8;
  localparam int OccW       = 5;
  localparam int InDataW    = 24;
  localparam int OutDataW   = 32;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // contents of one queue slot
  typedef struct packed {
    logic            valid;
    logic [PriW-1:0] pri;
    logic [IdW-1:0]  id;
  } slot_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [PriW-1:0] pri;
    logic [IdW-1:0]  id;
  } ctl_t;

endpackage

FILE: hw/rtl/prq_cell.sv
// one slot of the sorted queue chain
// depends on prq_pkg
module prq_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  prq_pkg::ctl_t  ctl_i,
  input  prq_pkg::slot_t left_i,
  input  logic          left_gt_i,
  input  prq_pkg::slot_t right_i,
  output prq_pkg::slot_t slot_o,
  output logic          gt_o
);
  import prq_pkg::*;

  logic            valid_r, valid_nxt;
  logic [PriW-1:0] pri_r, pri_nxt;
  logic [IdW-1:0]  id_r, id_nxt;

  // stored entry ranks behind the incoming one
  assign gt_o = valid_r && (pri_r > ctl_i.pri);
  assign slot_o = '{valid: valid_r, pri: pri_r, id: id_r};

  // insert shifts right from the first larger priority, remove shifts left
  always_comb begin
    valid_nxt = valid_r;
    pri_nxt   = pri_r;
    id_nxt    = id_r;
    if (ctl_i.ins) begin
      if (left_gt_i) begin
        valid_nxt = 1'b1;
        pri_nxt   = left_i.pri;
        id_nxt    = left_i.id;
      end else if ((gt_o || !valid_r) && left_i.valid) begin
        valid_nxt = 1'b1;
        pri_nxt   = ctl_i.pri;
        id_nxt    = ctl_i.id;
      end
    end else if (ctl_i.rem) begin
      valid_nxt = right_i.valid;
      pri_nxt   = right_i.pri;
      id_nxt    = right_i.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    pri_r <= pri_nxt;
    id_r  <= id_nxt;
  end

endmodule

FILE: hw/rtl/priority_ready_queue.sv
// priority ready queue: top level with the cell chain and result register
// depends on prq_pkg, prq_cell and priority_ready_queue_macros.svh
//
// Usage:
//   Input channel in_*: in_tuser is the mode (0 insert, 1 remove), in_tdata
//   carries proc_id and priority_req. Result channel out_*: one result per
//   accepted input, with the removed head entry, a status code (done, full,
//   empty) and the occupancy after the transaction.
//   Entries sit in a chain of QueueDepth cells, sorted by priority, smaller
//   first, equal priorities in arrival order. Every cell compares its own
//   priority with the request and all cells shift at once, so one transaction
//   is taken per cycle while in_tready is high; the result is registered and
//   appears in the cycle after acceptance. When the receiver stalls, the
//   result holds in the output register and in_tready drops until it is
//   taken; in_tready is high whenever the output register is empty or being
//   drained. Reset clears every valid bit and the count: the queue starts
//   empty and is usable as soon as reset is released.
`include "priority_ready_queue_macros.svh"
module priority_ready_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // proc_id [15:0], priority_req [23:16]
  input  logic [prq_pkg::InDataW-1:0]   in_tdata,
  // mode
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // removed_id [15:0], removed_priority [23:16], status [25:24],
  // occupancy [30:26], zero [31]
  output logic [prq_pkg::OutDataW-1:0]  out_tdata
);
  import prq_pkg::*;

  localparam logic MODE_INSERT = 1'b0;

  slot_t                slots   [QueueDepth];
  logic [QueueDepth-1:0] gts;
  logic [QueueDepth-1:0] valid_vec;
  ctl_t                 ctl;
  logic                 accept, full, empty;

  logic                 out_valid_r, out_valid_nxt;
  logic [IdW-1:0]       rid_r, rid_nxt;
  logic [PriW-1:0]      rpri_r, rpri_nxt;
  status_t              status_r, status_nxt;
  logic [OccW-1:0]      count_r, count_nxt;
  logic [OccW-1:0]      occ_r, occ_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = slots[QueueDepth-1].valid;
  assign empty     = !slots[0].valid;

  // broadcast operation
  assign ctl.ins = accept && (in_tuser == MODE_INSERT) && !full;
  assign ctl.rem = accept && (in_tuser != MODE_INSERT) && !empty;
  assign ctl.id  = in_tdata[IdW-1:0];
  assign ctl.pri = in_tdata[IdW+PriW-1:IdW];

  // cell chain, head at index 0
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    slot_t left_s, right_s;
    logic  left_gt;
    if (i == 0) begin : g_head
      assign left_s  = '{valid: 1'b1, pri: '0, id: '0};
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_s  = slots[i-1];
      assign left_gt = gts[i-1];
    end
    if (i == QueueDepth-1) begin : g_tail
      assign right_s = '{valid: 1'b0, pri: '0, id: '0};
    end else begin : g_inner
      assign right_s = slots[i+1];
    end
    prq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl),
      .left_i    (left_s),
      .left_gt_i (left_gt),
      .right_i   (right_s),
      .slot_o    (slots[i]),
      .gt_o      (gts[i])
    );
    assign valid_vec[i] = slots[i].valid;
  end

  // result and occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    rid_nxt       = rid_r;
    rpri_nxt      = rpri_r;
    status_nxt    = status_r;
    occ_nxt       = occ_r;
    count_nxt     = count_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.rem) begin
      count_nxt = count_r - 1'b1;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      rid_nxt       = ctl.rem ? slots[0].id : '0;
      rpri_nxt      = ctl.rem ? slots[0].pri : '0;
      occ_nxt       = count_nxt;
      priority if (ctl.ins || ctl.rem) begin
        status_nxt = ST_DONE;
      end else if (in_tuser == MODE_INSERT) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rid_r    <= rid_nxt;
    rpri_r   <= rpri_nxt;
    status_r <= status_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, occ_r, status_r, rpri_r, rid_r};

  // valid slots form a prefix of the chain
  `PRQ_ASSERT(a_valid_prefix, clk, rst_n,
    $onehot({1'b0, valid_vec} + {{QueueDepth{1'b0}}, 1'b1}))
  // head never ranks behind the second entry
  `PRQ_ASSERT_IMP(a_head_sorted, clk, rst_n, slots[1].valid,
    slots[0].pri <= slots[1].pri)
  // refused insert reports a full queue
  `PRQ_ASSERT_IMP(a_full_occ, clk, rst_n, out_valid_r && (status_r == ST_FULL),
    occ_r == QueueDepth[OccW-1:0])
  // remove on empty reports an empty queue with zero payload
  `PRQ_ASSERT_IMP(a_empty_occ, clk, rst_n, out_valid_r && (status_r == ST_EMPTY),
    (occ_r == '0) && (rid_r == '0) && (rpri_r == '0))
  // count follows the tail of the chain
  `PRQ_ASSERT(a_count_track, clk, rst_n,
    (count_r == QueueDepth[OccW-1:0]) == full)

endmodule

FILE: test/priority_ready_queue_checker.sv
// result checker for the priority ready queue: mirrors the sorted queue,
// predicts one result per input transaction and compares field by field
// depends on prq_pkg; also holds prq_tb_pkg with the operation codes
`timescale 1ns / 100ps

package prq_tb_pkg;

  // operation carried on in_tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

endpackage

module priority_ready_queue_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [prq_pkg::InDataW-1:0]  in_tdata,
  input  logic                         in_tuser,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [prq_pkg::OutDataW-1:0] out_tdata,
  output int                           fail_count,
  output int                           pending_count
);
  import prq_pkg::*;
  import prq_tb_pkg::*;

  // bit positions of the result fields in out_tdata
  localparam int PriLo  = IdW;
  localparam int StatLo = IdW + PriW;
  localparam int OccLo  = StatLo + 2;
  localparam int PadLo  = OccLo + OccW;

  // one predicted result
  typedef struct packed {
    logic [IdW-1:0]  removed_id;
    logic [PriW-1:0] removed_pri;
    status_t         status;
    logic [OccW-1:0] occupancy;
  } pop_report_t;

  // mirror of the queue contents, slot 0 is the head
  logic [IdW-1:0]  held_id  [QueueDepth];
  logic [PriW-1:0] held_pri [QueueDepth];
  int              held_count;

  pop_report_t awaited_reports [$];
  int          results_seen;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    held_count    = 0;
    results_seen  = 0;
  end

  task automatic report_fault(input string msg);
    $display("[%0t] queue checker: %s", $time, msg);
    fail_count++;
  endtask

  // apply one transaction to the mirror and return the result it causes
  function automatic pop_report_t serve_transaction(input op_t op,
                                                    input logic [IdW-1:0] id,
                                                    input logic [PriW-1:0] pri);
    pop_report_t rep;
    int          slot;
    int          pos;
    rep = '0;
    if (op == OP_INSERT) begin
      if (held_count >= QueueDepth) begin
        rep.status = ST_FULL;
      end else begin
        // ahead of the first entry with a strictly larger priority
        pos = held_count;
        for (slot = held_count - 1; slot >= 0; slot--) begin
          if (held_pri[slot] > pri) pos = slot;
        end
        for (slot = held_count; slot > pos; slot--) begin
          held_id[slot]  = held_id[slot-1];
          held_pri[slot] = held_pri[slot-1];
        end
        held_id[pos]  = id;
        held_pri[pos] = pri;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        rep.status = ST_EMPTY;
      end else begin
        rep.removed_id  = held_id[0];
        rep.removed_pri = held_pri[0];
        for (slot = 0; slot + 1 < held_count; slot++) begin
          held_id[slot]  = held_id[slot+1];
          held_pri[slot] = held_pri[slot+1];
        end
        held_count--;
      end
    end
    rep.occupancy = OccW'(held_count);
    return rep;
  endfunction

  // compare one result transaction with the oldest prediction
  task automatic check_result(input logic [OutDataW-1:0] word);
    pop_report_t want;
    if (awaited_reports.size() == 0) begin
      report_fault($sformatf("result %0d arrived with nothing pending, data %h",
                             results_seen, word));
    end else begin
      want = awaited_reports.pop_front();
      if (word[IdW-1:0] != want.removed_id)
        report_fault($sformatf("result %0d removed_id got %h want %h", results_seen,
                               word[IdW-1:0], want.removed_id));
      if (word[StatLo-1:PriLo] != want.removed_pri)
        report_fault($sformatf("result %0d removed_priority got %h want %h", results_seen,
                               word[StatLo-1:PriLo], want.removed_pri));
      if (word[OccLo-1:StatLo] != want.status)
        report_fault($sformatf("result %0d status got %0d want %0d", results_seen,
                               word[OccLo-1:StatLo], want.status));
      if (word[PadLo-1:OccLo] != want.occupancy)
        report_fault($sformatf("result %0d occupancy got %0d want %0d", results_seen,
                               word[PadLo-1:OccLo], want.occupancy));
      if (word[OutDataW-1:PadLo] != '0)
        report_fault($sformatf("result %0d padding bits not zero, data %h",
                               results_seen, word));
    end
    results_seen++;
  endtask

  // results first, so a same-edge input never satisfies its own check
  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      awaited_reports.delete();
      pending_count = 0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) begin
        awaited_reports.insert(awaited_reports.size(),
                               serve_transaction(op_t'(in_tuser),
                                                 in_tdata[IdW-1:0],
                                                 in_tdata[IdW+PriW-1:IdW]));
      end
      pending_count = awaited_reports.size();
    end
  end

endmodule

FILE: test/tb_priority_ready_queue.sv
// testbench top for the priority ready queue: clock, reset, stimulus and verdict
// depends on prq_pkg, priority_ready_queue and priority_ready_queue_checker
`timescale 1ns / 100ps

module tb_priority_ready_queue;
  import prq_pkg::*;
  import prq_tb_pkg::*;

  localparam int ItemTotal  = 1850;
  localparam int LongHold   = 150;
  localparam int DrainTail  = 4;
  localparam int RunLimitNs = 5_000_000;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tuser   = OP_INSERT;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  int                  fail_count;
  int                  pending_count;

  priority_ready_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  priority_ready_queue_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one transaction after a random gap, none if calm, and await acceptance
  task automatic offer_item(input op_t op, input logic [IdW-1:0] id,
                            input logic [PriW-1:0] pri, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pri, id};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering until every predicted result has been taken
  task automatic wait_for_drain;
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    int   sent;
    int   burst_len;
    int   style;
    int   insert_pct;
    int   k;
    bit   narrow;
    bit   calm;
    op_t  op;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // remove on empty, with all-ones in the ignored fields
    offer_item(OP_REMOVE, '1, '1, 1'b0);
    // extremes and ties, then fill the queue
    offer_item(OP_INSERT, 16'h0000, 8'h00, 1'b0);
    offer_item(OP_INSERT, 16'hffff, 8'hff, 1'b0);
    offer_item(OP_INSERT, 16'h1234, 8'h80, 1'b0);
    offer_item(OP_INSERT, 16'h5678, 8'h80, 1'b0);
    offer_item(OP_INSERT, 16'haaaa, 8'h00, 1'b0);
    offer_item(OP_INSERT, 16'h5555, 8'hff, 1'b0);
    offer_item(OP_INSERT, 16'h0001, 8'h7f, 1'b0);
    for (k = 0; k < QueueDepth - 7; k++) begin
      offer_item(OP_INSERT, IdW'($urandom), PriW'($urandom_range(0, 255)), 1'b0);
    end
    // insert into a full queue, at the best priority
    offer_item(OP_INSERT, 16'hffff, 8'h00, 1'b0);
    for (k = 0; k < 5; k++) begin
      offer_item(OP_REMOVE, IdW'($urandom), PriW'($urandom), 1'b0);
    end
    sent = QueueDepth + 7;
    wait_for_drain();

    // random bursts, each leaning toward filling, draining or balance
    while (sent < ItemTotal) begin
      burst_len  = $urandom_range(8, 60);
      style      = $urandom_range(0, 2);
      insert_pct = (style == 0) ? 80 : (style == 1) ? 20 : 50;
      narrow     = ($urandom_range(0, 2) == 0);
      calm       = ($urandom_range(0, 4) == 0);
      for (k = 0; k < burst_len && sent < ItemTotal; k++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        offer_item(op, IdW'($urandom),
                   PriW'(narrow ? $urandom_range(0, 3) : $urandom_range(0, 255)),
                   calm);
        sent++;
        if (sent == 700 || sent == 1400) wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (DrainTail) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result receiver: random stalls, calm stretches and two long hold-offs
  initial begin
    int taken;
    int stall;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 300 || taken == 1100) begin
        stall = LongHold;
      end else if ((taken / 80) % 4 == 3) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 14);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // run limit
  initial begin
    #(RunLimitNs);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/prq_pkg.sv
hw/rtl/prq_cell.sv
hw/rtl/priority_ready_queue.sv
test/priority_ready_queue_checker.sv
test/tb_priority_ready_queue.sv
